### rtl/core/gag_pkg.sv
// Shared types and constants of the grid axis gradient core.
package gag_pkg;

    localparam int DER_W       = 19;
    localparam int IDX_W       = 10;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_IDX_W-1:0] REG_AXIS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam int PEND_FIRST = 0;
    localparam int PEND_MID   = 1;
    localparam int PEND_LAST  = 2;

    typedef struct packed {
        logic signed [DER_W-1:0] first_num;
        logic signed [DER_W-1:0] mid_num;
        logic signed [DER_W-1:0] last_num;
    } nums_t;

endpackage

### rtl/core/gag_line_store.sv
// Pair of line memories holding the two previous rows, one entry per column.
module gag_line_store #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_upper,
    input  logic [DATA_W-1:0] wr_lower,
    output logic [DATA_W-1:0] rd_upper,
    output logic [DATA_W-1:0] rd_lower
);

    logic [DATA_W-1:0] upper_mem [DEPTH];
    logic [DATA_W-1:0] lower_mem [DEPTH];
    logic [DATA_W-1:0] rd_upper_reg;
    logic [DATA_W-1:0] rd_lower_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr] <= wr_upper;
            lower_mem[wr_addr] <= wr_lower;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_upper_reg <= upper_mem[rd_addr];
            rd_lower_reg <= lower_mem[rd_addr];
        end
    end

    assign rd_upper = rd_upper_reg;
    assign rd_lower = rd_lower_reg;

endmodule

### rtl/core/gag_stencil.sv
// Second-order difference stencils: one-sided at the ends, central inside.
module gag_stencil #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic signed [SAMPLE_BITS-1:0] far_val,
    input  logic signed [SAMPLE_BITS-1:0] near_val,
    input  logic signed [SAMPLE_BITS-1:0] cur_val,
    output gag_pkg::nums_t                nums
);

    localparam int RW = (SAMPLE_BITS + 4 > gag_pkg::DER_W) ? SAMPLE_BITS + 4 : gag_pkg::DER_W;

    logic signed [RW-1:0] a_x;
    logic signed [RW-1:0] b_x;
    logic signed [RW-1:0] x_x;
    logic signed [RW-1:0] a3;
    logic signed [RW-1:0] b4;
    logic signed [RW-1:0] x3;
    logic signed [RW-1:0] first_w;
    logic signed [RW-1:0] mid_w;
    logic signed [RW-1:0] last_w;

    always_comb
    begin
        a_x     = RW'(far_val);
        b_x     = RW'(near_val);
        x_x     = RW'(cur_val);
        a3      = (a_x <<< 1) + a_x;
        b4      = b_x <<< 2;
        x3      = (x_x <<< 1) + x_x;
        first_w = b4 - a3 - x_x;
        mid_w   = x_x - a_x;
        last_w  = x3 - b4 + a_x;
        nums.first_num = first_w[gag_pkg::DER_W-1:0];
        nums.mid_num   = mid_w[gag_pkg::DER_W-1:0];
        nums.last_num  = last_w[gag_pkg::DER_W-1:0];
    end

endmodule

### rtl/core/grid_axis_gradient_core.sv
// Top level of the streaming grid gradient core.
//
//  Channel   Dir  Signals                               Contents
//  s_axis    in   tvalid tready tdata                   one raster sample
//  m_axis    out  tvalid tready tdata tlast             one derivative result
//  cfg       in   cfg_valid cfg_ready cfg_index cfg_data register write
//
// A sample is accepted and its line store entry is read at once; the results are formed
// in the next cycle and leave through the output register. Up to three results per sample
// go out at one per cycle while m_axis is not stalled; a sample that causes several results
// holds the input until its last one is loaded, otherwise one sample a cycle. The line
// stores need no clearing after reset and the block is ready at once. Unless a register
// write intervenes, consecutive samples address different columns, so no forwarding is needed.
module grid_axis_gradient_core #(
    parameter int MAX_COLS    = 1024,
    parameter int MAX_ROWS    = 1024,
    parameter int SAMPLE_BITS = 16,
    localparam int IN_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [IN_TDATA_W-1:0]              s_axis_tdata,   // sample
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [gag_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,   // derivative_twice, out_row, out_col
    output logic                               m_axis_tlast,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gag_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [gag_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CW  = $clog2(MAX_COLS);
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CXW = (CW > gag_pkg::IDX_W) ? CW : gag_pkg::IDX_W;
    localparam int RXW = (RW > gag_pkg::IDX_W) ? RW : gag_pkg::IDX_W;
    localparam int WXW = (CW + 1 > gag_pkg::CFG_DATA_W) ? CW + 1 : gag_pkg::CFG_DATA_W;
    localparam int HXW = (RW + 1 > gag_pkg::CFG_DATA_W) ? RW + 1 : gag_pkg::CFG_DATA_W;
    localparam int DW  = gag_pkg::DER_W;
    localparam int PAD = gag_pkg::OUT_TDATA_W - DW - 2 * gag_pkg::IDX_W;

    logic                   axis_reg;
    logic [CW-1:0]          wlast_reg;
    logic [RW-1:0]          hlast_reg;
    logic [CW-1:0]          col_reg;
    logic [RW-1:0]          row_reg;
    logic [SAMPLE_BITS-1:0] prev_one_reg;
    logic [SAMPLE_BITS-1:0] prev_two_reg;

    logic                   s1_valid_reg;
    logic [2:0]             s1_pend_reg;
    logic [2:0]             s1_pend_next;
    logic                   s1_axis_reg;
    logic [CW-1:0]          s1_col_reg;
    logic [RW-1:0]          s1_row_reg;
    logic [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [SAMPLE_BITS-1:0] s1_p1_reg;
    logic [SAMPLE_BITS-1:0] s1_p2_reg;

    logic                              m_valid_reg;
    logic [gag_pkg::OUT_TDATA_W-1:0]   m_tdata_reg;
    logic                              m_tlast_reg;

    logic                   in_fire;
    logic                   cfg_fire;
    logic                   out_load_ok;
    logic                   emit;
    logic                   s1_done;
    logic [2:0]             sel;
    logic [2:0]             pend_after;
    logic [2:0]             pend_new;
    logic                   k_is_two;
    logic                   k_ge_two;
    logic                   k_is_end;
    logic [SAMPLE_BITS-1:0] rd_upper;
    logic [SAMPLE_BITS-1:0] rd_lower;
    logic [SAMPLE_BITS-1:0] far_val;
    logic [SAMPLE_BITS-1:0] near_val;
    gag_pkg::nums_t         nums;
    logic [DW-1:0]          der_sel;
    logic [RW-1:0]          row_sel;
    logic [CW-1:0]          col_sel;
    logic [RXW-1:0]         row_x;
    logic [CXW-1:0]         col_x;
    logic [WXW-1:0]         w_ext;
    logic [HXW-1:0]         h_ext;
    logic [CW-1:0]          wlast_cfg;
    logic [RW-1:0]          hlast_cfg;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    // Saturate the written sizes and keep them as the index of the last position.
    always_comb
    begin
        w_ext = WXW'(cfg_data);
        h_ext = HXW'(cfg_data);
        if (w_ext < WXW'(3))
            wlast_cfg = CW'(2);
        else if (w_ext > WXW'(MAX_COLS))
            wlast_cfg = CW'(MAX_COLS - 1);
        else
            wlast_cfg = CW'(w_ext - WXW'(1));
        if (h_ext < HXW'(3))
            hlast_cfg = RW'(2);
        else if (h_ext > HXW'(MAX_ROWS))
            hlast_cfg = RW'(MAX_ROWS - 1);
        else
            hlast_cfg = RW'(h_ext - HXW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg  <= 1'b0;
            wlast_reg <= CW'(2);
            hlast_reg <= RW'(2);
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                gag_pkg::REG_AXIS:   axis_reg  <= cfg_data[0];
                gag_pkg::REG_WIDTH:  wlast_reg <= wlast_cfg;
                gag_pkg::REG_HEIGHT: hlast_reg <= hlast_cfg;
                default:             ;
            endcase
            if (cfg_index == gag_pkg::REG_AXIS || cfg_index == gag_pkg::REG_WIDTH ||
                cfg_index == gag_pkg::REG_HEIGHT)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
        end
        else if (in_fire)
        begin
            if (col_reg == wlast_reg)
            begin
                col_reg <= '0;
                row_reg <= (row_reg == hlast_reg) ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_one_reg <= '0;
            prev_two_reg <= '0;
        end
        else if (in_fire)
        begin
            prev_two_reg <= prev_one_reg;
            prev_one_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
    end

    // Which results the new sample causes: the start pair, the interior point, the end.
    always_comb
    begin
        if (axis_reg)
        begin
            k_is_two = (row_reg == RW'(2));
            k_ge_two = (row_reg >= RW'(2));
            k_is_end = (row_reg == hlast_reg);
        end
        else
        begin
            k_is_two = (col_reg == CW'(2));
            k_ge_two = (col_reg >= CW'(2));
            k_is_end = (col_reg == wlast_reg);
        end
        pend_new                     = '0;
        pend_new[gag_pkg::PEND_FIRST] = k_is_two;
        pend_new[gag_pkg::PEND_MID]   = k_ge_two;
        pend_new[gag_pkg::PEND_LAST]  = k_ge_two && k_is_end;
    end

    always_comb
    begin
        out_load_ok = !m_valid_reg || m_axis_tready;
        sel = s1_pend_reg & (~s1_pend_reg + 3'd1);
        pend_after = s1_pend_reg & ~sel;
        emit = s1_valid_reg && (s1_pend_reg != 3'd0) && out_load_ok;
        s1_done = s1_valid_reg && ((s1_pend_reg == 3'd0) || (emit && pend_after == 3'd0));
        s1_pend_next = emit ? pend_after : s1_pend_reg;
    end

    assign s_axis_tready = !s1_valid_reg || s1_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_pend_reg  <= '0;
        end
        else if (in_fire)
        begin
            s1_valid_reg <= 1'b1;
            s1_pend_reg  <= pend_new;
        end
        else
        begin
            if (s1_done)
                s1_valid_reg <= 1'b0;
            s1_pend_reg <= s1_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_axis_reg   <= axis_reg;
            s1_col_reg    <= col_reg;
            s1_row_reg    <= row_reg;
            s1_sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
            s1_p1_reg     <= prev_one_reg;
            s1_p2_reg     <= prev_two_reg;
        end
    end

    gag_line_store #(
        .DEPTH  (MAX_COLS),
        .DATA_W (SAMPLE_BITS)
    ) u_line_store (
        .clk      (clk),
        .rd_en    (in_fire),
        .rd_addr  (col_reg),
        .wr_en    (s1_done),
        .wr_addr  (s1_col_reg),
        .wr_upper (rd_lower),
        .wr_lower (s1_sample_reg),
        .rd_upper (rd_upper),
        .rd_lower (rd_lower)
    );

    assign far_val  = s1_axis_reg ? rd_upper : s1_p2_reg;
    assign near_val = s1_axis_reg ? rd_lower : s1_p1_reg;

    gag_stencil #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_stencil (
        .far_val  (far_val),
        .near_val (near_val),
        .cur_val  (s1_sample_reg),
        .nums     (nums)
    );

    always_comb
    begin
        der_sel = nums.last_num;
        row_sel = s1_row_reg;
        col_sel = s1_col_reg;
        if (sel[gag_pkg::PEND_FIRST])
        begin
            der_sel = nums.first_num;
            row_sel = s1_axis_reg ? '0 : s1_row_reg;
            col_sel = s1_axis_reg ? s1_col_reg : '0;
        end
        else if (sel[gag_pkg::PEND_MID])
        begin
            der_sel = nums.mid_num;
            row_sel = s1_axis_reg ? s1_row_reg - RW'(1) : s1_row_reg;
            col_sel = s1_axis_reg ? s1_col_reg : s1_col_reg - CW'(1);
        end
        row_x = RXW'(row_sel);
        col_x = CXW'(col_sel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_load_ok)
            m_valid_reg <= emit;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            m_tdata_reg <= {PAD'(0), col_x[gag_pkg::IDX_W-1:0], row_x[gag_pkg::IDX_W-1:0],
                            der_sel};
            m_tlast_reg <= (pend_after == 3'd0);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tlast  = m_tlast_reg;

endmodule

### rtl/core/gag_checker.sv
// Port-level checks of the grid axis gradient core, bound to the top level.
module gag_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [gag_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tlast,
    input logic                            cfg_valid,
    input logic                            cfg_ready
);

    // A stalled result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
            $stable(m_axis_tlast))
    else $error("stalled result changed");

    // The remaining results of one sample follow without a gap.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a run of results");

    // Leaving reset, no result is shown.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
    else $error("result shown straight out of reset");

    // Register writes are always taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
    else $error("register write refused");

endmodule

bind grid_axis_gradient_core gag_checker u_gag_checker (.*);

### verif/grid_axis_gradient_core_tb.sv
// Self-checking testbench for the streaming grid gradient core.
`timescale 1ns / 100ps

module grid_axis_gradient_core_tb;

    localparam int MAX_COLS     = 1024;
    localparam int MAX_ROWS     = 1024;
    localparam int DER_W        = gag_pkg::DER_W;
    localparam int IDX_W        = gag_pkg::IDX_W;
    localparam int ROW_LSB      = DER_W;
    localparam int COL_LSB      = DER_W + IDX_W;
    localparam int ITEM_TARGET  = 430;
    localparam int QUIET_LIMIT  = 5000;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic signed [DER_W-1:0] der;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic                    run_end;
    } grad_result_t;

    class gradient_ledger;
        grad_result_t pending_grads[$];
        int           mismatches;
        bit           axis_rows;
        int           width_reg;
        int           height_reg;
        int           col_pos;
        int           row_pos;
        int           prev_one;
        int           prev_two;
        int           upper_line[MAX_COLS];
        int           lower_line[MAX_COLS];

        function new();
            mismatches = 0;
            axis_rows  = 1'b0;
            width_reg  = 3;
            height_reg = 3;
            col_pos    = 0;
            row_pos    = 0;
            prev_one   = 0;
            prev_two   = 0;
        endfunction

        function int clamp_dim(int v, int hi);
            if (v < 3)
                return 3;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function void set_reg(logic [gag_pkg::CFG_IDX_W-1:0] idx,
                              logic [gag_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                gag_pkg::REG_AXIS:   axis_rows  = val[0];
                gag_pkg::REG_WIDTH:  width_reg  = int'(val);
                gag_pkg::REG_HEIGHT: height_reg = int'(val);
                default:             return;
            endcase
            col_pos = 0;
            row_pos = 0;
        endfunction

        function void push_grad(int val, int r, int c);
            grad_result_t g;
            g.der     = val[DER_W-1:0];
            g.row     = r[IDX_W-1:0];
            g.col     = c[IDX_W-1:0];
            g.run_end = 1'b0;
            pending_grads.push_back(g);
        endfunction

        function void predict_gradients(logic [15:0] s);
            int w;
            int h;
            int c;
            int r;
            int x;
            int up;
            int lo;
            int before_count;
            grad_result_t g;
            w = clamp_dim(width_reg, MAX_COLS);
            h = clamp_dim(height_reg, MAX_ROWS);
            c = col_pos;
            r = row_pos;
            x = int'($signed(s));
            before_count = pending_grads.size();
            if (!axis_rows)
            begin
                if (c == 2)
                begin
                    push_grad(-3 * prev_two + 4 * prev_one - x, r, 0);
                    push_grad(x - prev_two, r, 1);
                end
                else if (c > 2)
                    push_grad(x - prev_two, r, c - 1);
                if (c >= 2 && c >= w - 1)
                    push_grad(3 * x - 4 * prev_one + prev_two, r, c);
            end
            else
            begin
                up = upper_line[c];
                lo = lower_line[c];
                if (r == 2)
                begin
                    push_grad(-3 * up + 4 * lo - x, 0, c);
                    push_grad(x - up, 1, c);
                end
                else if (r > 2)
                    push_grad(x - up, r - 1, c);
                if (r >= 2 && r >= h - 1)
                    push_grad(3 * x - 4 * lo + up, r, c);
            end
            upper_line[c] = lower_line[c];
            lower_line[c] = x;
            prev_two = prev_one;
            prev_one = x;
            if (c >= w - 1)
            begin
                col_pos = 0;
                row_pos = (r >= h - 1) ? 0 : r + 1;
            end
            else
                col_pos = c + 1;
            if (pending_grads.size() > before_count)
            begin
                g = pending_grads.pop_back();
                g.run_end = 1'b1;
                pending_grads.push_back(g);
            end
        endfunction

        function void check_gradient(logic [gag_pkg::OUT_TDATA_W-1:0] td, logic tl);
            grad_result_t g;
            logic signed [DER_W-1:0] der_seen;
            logic [IDX_W-1:0]        row_seen;
            logic [IDX_W-1:0]        col_seen;
            der_seen = td[DER_W-1:0];
            row_seen = td[ROW_LSB +: IDX_W];
            col_seen = td[COL_LSB +: IDX_W];
            if (pending_grads.size() == 0)
            begin
                $error("Unexpected result: derivative_twice %0d row %0d col %0d",
                       der_seen, row_seen, col_seen);
                mismatches++;
                return;
            end
            g = pending_grads.pop_front();
            if (der_seen !== g.der)
            begin
                $error("derivative_twice: expected %0d, actual %0d", g.der, der_seen);
                mismatches++;
            end
            if (row_seen !== g.row)
            begin
                $error("out_row: expected %0d, actual %0d", g.row, row_seen);
                mismatches++;
            end
            if (col_seen !== g.col)
            begin
                $error("out_col: expected %0d, actual %0d", g.col, col_seen);
                mismatches++;
            end
            if (tl !== g.run_end)
            begin
                $error("last_of_run: expected %0d, actual %0d", g.run_end, tl);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return pending_grads.size();
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n;
    logic                                s_axis_tvalid;
    logic                                s_axis_tready;
    logic [15:0]                         s_axis_tdata;
    logic                                m_axis_tvalid;
    logic                                m_axis_tready;
    logic [gag_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;
    logic                                m_axis_tlast;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [gag_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [gag_pkg::CFG_DATA_W-1:0]      cfg_data;

    gradient_ledger ledger;
    int  items_sent    = 0;
    int  burst_left    = 0;
    int  hold_requests = 0;
    int  quiet_cycles  = 0;
    bit  offering      = 1'b0;

    grid_axis_gradient_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            ledger.check_gradient(m_axis_tdata, m_axis_tlast);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin : result_sink
        int hold_left;
        int holds_served;
        int seg_left;
        int seg_mode;
        bit ready_next;
        hold_left    = 0;
        holds_served = 0;
        seg_left     = 0;
        seg_mode     = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_served != hold_requests)
            begin
                holds_served++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(10, 80);
                    seg_mode = $urandom_range(0, 3);
                end
                seg_left--;
                case (seg_mode)
                    0:       ready_next = 1'b1;
                    1:       ready_next = $urandom_range(0, 1);
                    2:       ready_next = ($urandom_range(0, 3) == 0);
                    default: ready_next = ($urandom_range(0, 7) != 0);
                endcase
            end
            m_axis_tready <= ready_next;
        end
    end

    function automatic logic [15:0] random_sample();
        case ($urandom_range(0, 7))
            0:       return ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
            1:       return ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
            2:       return 16'($urandom_range(0, 15) - 8);
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    function automatic int random_dim();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 2);
            1:       return 1024;
            2:       return ($urandom_range(0, 1) == 1) ? 2047 : 1025;
            default: return $urandom_range(3, 9);
        endcase
    endfunction

    task automatic drive_sample(input logic [15:0] v);
        int gap;
        s_axis_tdata  <= v;
        s_axis_tvalid <= 1'b1;
        offering = 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        ledger.predict_gradients(v);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                offering = 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic settle();
        if (offering)
        begin
            s_axis_tvalid <= 1'b0;
            offering = 1'b0;
        end
        while (ledger.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [gag_pkg::CFG_IDX_W-1:0] idx, input int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[gag_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        ledger.set_reg(idx, val[gag_pkg::CFG_DATA_W-1:0]);
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        int corner_a[] = '{32767, -32768, 32767, -32768, 32767, -32768, 0, -1, 1};
        int corner_b[] = '{32767, -32768, 32767, -32768, 32767, -32768,
                           32767, -32768, 32767, 1, -1, 0};
        int corner_c[] = '{7, -7, -32768, 32767};
        int phase_no;
        int new_axis;
        int new_w;
        int new_h;
        int cur_axis;
        int cur_w;
        int count;
        bit wr_axis;
        bit wr_w;
        bit wr_h;
        bit any_write;
        ledger = new();
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= gag_pkg::REG_AXIS;
        cfg_data      <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (corner_a[i])
            drive_sample(16'(corner_a[i]));
        settle();
        write_reg(gag_pkg::REG_AXIS, 1);
        write_reg(gag_pkg::REG_WIDTH, 1);
        write_reg(gag_pkg::REG_HEIGHT, 0);
        end_writes();
        foreach (corner_b[i])
            drive_sample(16'(corner_b[i]));
        settle();
        write_reg(gag_pkg::REG_AXIS, 0);
        write_reg(gag_pkg::REG_WIDTH, 2047);
        end_writes();
        foreach (corner_c[i])
            drive_sample(16'(corner_c[i]));

        cur_axis = 0;
        cur_w    = 2047;
        phase_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            phase_no++;
            settle();
            new_axis = $urandom_range(0, 1);
            new_w    = random_dim();
            new_h    = random_dim();
            wr_axis  = ($urandom_range(0, 3) != 0);
            wr_w     = ($urandom_range(0, 3) != 0);
            wr_h     = ($urandom_range(0, 3) != 0);
            if ((wr_axis ? new_axis : cur_axis) == 1 && (wr_w ? new_w : cur_w) > 16)
            begin
                new_w = $urandom_range(3, 16);
                wr_w  = 1'b1;
            end
            any_write = 1'b0;
            if (wr_axis)
            begin
                write_reg(gag_pkg::REG_AXIS, new_axis);
                cur_axis  = new_axis;
                any_write = 1'b1;
            end
            if (wr_w)
            begin
                write_reg(gag_pkg::REG_WIDTH, new_w);
                cur_w     = new_w;
                any_write = 1'b1;
            end
            if (wr_h)
            begin
                write_reg(gag_pkg::REG_HEIGHT, new_h);
                any_write = 1'b1;
            end
            if (any_write)
                end_writes();
            if (phase_no % 7 == 3)
            begin
                hold_requests++;
                count = 60;
            end
            else
                count = $urandom_range(4, 40);
            repeat (count) drive_sample(random_sample());
        end

        settle();
        if (ledger.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
